@@ sv/hrrn_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the hrrn batch scheduler
// no dependencies; used by every module of the block

package hrrn_pkg;

	localparam int MAX_PROCESSES = 64;
	localparam int SLOT_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int COUNT_W = $clog2(MAX_PROCESSES + 1);
	localparam int ID_W    = 16;
	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int TIME_W  = 23;
	localparam int NUM_W   = TIME_W + 1;
	localparam int PROD_W  = NUM_W + BURST_W;

	// one stored job
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
	} job_entry_t;

	// outcome of one cross-multiplied ratio compare
	typedef struct packed {
		logic gt;
		logic eq;
	} ratio_cmp_t;

	// sequencer states
	typedef enum logic [4:0] {
		S_LOAD   = 5'b00001,
		S_PREP   = 5'b00010,
		S_MUL    = 5'b00100,
		S_CMP    = 5'b01000,
		S_DECIDE = 5'b10000
	} state_t;

endpackage

@@ sv/hrrn_job_store.sv @@
`timescale 1ns / 1ps
// job memory: one write port, one read port with registered read data
// depends on hrrn_pkg

module hrrn_job_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [hrrn_pkg::SLOT_W-1:0] waddr,
	input  hrrn_pkg::job_entry_t       wdata,
	input  logic [hrrn_pkg::SLOT_W-1:0] raddr,
	output hrrn_pkg::job_entry_t       rdata
);

	hrrn_pkg::job_entry_t mem_q [hrrn_pkg::MAX_PROCESSES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/hrrn_ratio_unit.sv @@
`timescale 1ns / 1ps
// shared cross-multiply unit: registers both products, then compares them
// depends on hrrn_pkg

module hrrn_ratio_unit (
	input  logic                         clk,
	input  logic                         load,
	input  logic [hrrn_pkg::NUM_W-1:0]   cand_num,
	input  logic [hrrn_pkg::BURST_W-1:0] cand_burst,
	input  logic [hrrn_pkg::NUM_W-1:0]   best_num,
	input  logic [hrrn_pkg::BURST_W-1:0] best_burst,
	output hrrn_pkg::ratio_cmp_t         cmp
);

	logic [hrrn_pkg::PROD_W-1:0] lhs_q;
	logic [hrrn_pkg::PROD_W-1:0] rhs_q;

	always_ff @(posedge clk) begin
		if (load) begin
			lhs_q <= hrrn_pkg::PROD_W'(cand_num) * hrrn_pkg::PROD_W'(best_burst);
			rhs_q <= hrrn_pkg::PROD_W'(best_num) * hrrn_pkg::PROD_W'(cand_burst);
		end
	end

	assign cmp.gt = lhs_q > rhs_q;
	assign cmp.eq = lhs_q == rhs_q;

endmodule

@@ sv/hrrn_batch_scheduler_core.sv @@
`timescale 1ns / 1ps
// top level of the hrrn batch scheduler: load sequencer and dispatch scan
// depends on hrrn_pkg, hrrn_job_store, hrrn_ratio_unit
//
// usage
//  - input channel: a job transfer happens at a rising edge with start high
//    and busy low; the job goes to the next free slot (dropped when the
//    batch already holds MAX_PROCESSES jobs)
//  - a job with last_job set closes the batch and starts scheduling;
//    busy stays high until the last schedule entry has been sent
//  - output channel: each schedule entry sits on the result ports for one
//    cycle with result_valid high; the receiver cannot stall, it must take
//    the entry in that cycle
//  - loading takes one job per cycle while busy is low; a non-final job never raises busy
//  - scheduling a batch of n jobs: each scan round runs one prep state, a
//    multiply and a compare state per stored slot and one decide state,
//    all through the single shared cross-multiplier; every dispatch takes
//    one round, plus one more round when the clock has to jump forward to
//    the next arrival (the first round of a batch always starts from tick
//    zero)
//  - reset clears the job count, done marks and sequencer; stored job
//    payload is not cleared and is only read after it has been written

module hrrn_batch_scheduler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [hrrn_pkg::ID_W-1:0]     job_id,
	input  logic [hrrn_pkg::ARR_W-1:0]    arrival_time,
	input  logic [hrrn_pkg::BURST_W-1:0]  burst_time,
	input  logic                          last_job,
	output logic                          result_valid,
	output logic [hrrn_pkg::ID_W-1:0]     sched_id,
	output logic [hrrn_pkg::TIME_W-1:0]   start_time,
	output logic [hrrn_pkg::TIME_W-1:0]   finish_time,
	output logic                          last_entry
);

	hrrn_pkg::state_t state_q;

	// batch bookkeeping
	logic [hrrn_pkg::COUNT_W-1:0]       job_count_q;
	logic [hrrn_pkg::COUNT_W-1:0]       n_q;
	logic [hrrn_pkg::COUNT_W-1:0]       dispatched_q;
	logic [hrrn_pkg::MAX_PROCESSES-1:0] done_q;
	logic [hrrn_pkg::TIME_W-1:0]        now_q;

	// scan state
	logic [hrrn_pkg::SLOT_W-1:0]  idx_q;
	logic                         found_q;
	logic [hrrn_pkg::ARR_W-1:0]   min_q;

	// candidate held between the multiply and compare cycles
	logic [hrrn_pkg::ID_W-1:0]    cand_id_q;
	logic [hrrn_pkg::ARR_W-1:0]   cand_arr_q;
	logic [hrrn_pkg::BURST_W-1:0] cand_burst_q;
	logic [hrrn_pkg::NUM_W-1:0]   cand_num_q;
	logic                         cand_ready_q;
	logic                         cand_undone_q;

	// current best job of this scan
	logic [hrrn_pkg::SLOT_W-1:0]  best_slot_q;
	logic [hrrn_pkg::ID_W-1:0]    best_id_q;
	logic [hrrn_pkg::ARR_W-1:0]   best_arr_q;
	logic [hrrn_pkg::BURST_W-1:0] best_burst_q;
	logic [hrrn_pkg::NUM_W-1:0]   best_num_q;

	// memory and ratio unit hookup
	logic                          accept;
	logic                          store_we;
	hrrn_pkg::job_entry_t          store_wdata;
	logic [hrrn_pkg::SLOT_W-1:0]   rd_addr;
	hrrn_pkg::job_entry_t          rd_data;
	logic [hrrn_pkg::NUM_W-1:0]    rd_num;
	hrrn_pkg::ratio_cmp_t          cmp;
	logic                          take_cand;
	logic                          scan_last;
	logic [hrrn_pkg::TIME_W-1:0]   finish_now;
	logic                          batch_end;

	assign busy   = (state_q != hrrn_pkg::S_LOAD);
	assign accept = start && !busy;

	// a job is stored only while the batch has room
	assign store_we = accept && (job_count_q < hrrn_pkg::COUNT_W'(hrrn_pkg::MAX_PROCESSES));
	assign store_wdata.id      = job_id;
	assign store_wdata.arrival = arrival_time;
	// zero burst is raised to one tick
	assign store_wdata.burst   = (burst_time == '0) ? hrrn_pkg::BURST_W'(1) : burst_time;

	// read address: slot zero at scan start, next slot during each compare
	always_comb begin
		unique case (state_q)
			hrrn_pkg::S_CMP: rd_addr = hrrn_pkg::SLOT_W'(idx_q + 1'b1);
			default:         rd_addr = '0;
		endcase
	end

	hrrn_job_store u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (job_count_q[hrrn_pkg::SLOT_W-1:0]),
		.wdata (store_wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// response ratio numerator: wait plus burst (only meaningful when arrived)
	assign rd_num = hrrn_pkg::NUM_W'(now_q - hrrn_pkg::TIME_W'(rd_data.arrival))
		+ hrrn_pkg::NUM_W'(rd_data.burst);

	hrrn_ratio_unit u_ratio (
		.clk        (clk),
		.load       (state_q == hrrn_pkg::S_MUL),
		.cand_num   (rd_num),
		.cand_burst (rd_data.burst),
		.best_num   (best_num_q),
		.best_burst (best_burst_q),
		.cmp        (cmp)
	);

	// candidate wins on higher ratio, then on earlier arrival; on a full tie
	// the earlier slot (already best) stays
	assign take_cand = cand_ready_q
		&& (!found_q || cmp.gt || (cmp.eq && (cand_arr_q < best_arr_q)));
	assign scan_last  = (hrrn_pkg::COUNT_W'(idx_q) == hrrn_pkg::COUNT_W'(n_q - 1'b1));
	assign finish_now = hrrn_pkg::TIME_W'(now_q + hrrn_pkg::TIME_W'(best_burst_q));
	assign batch_end  = (hrrn_pkg::COUNT_W'(dispatched_q + 1'b1) == n_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hrrn_pkg::S_LOAD;
			job_count_q  <= '0;
			n_q          <= '0;
			dispatched_q <= '0;
			done_q       <= '0;
			now_q        <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				hrrn_pkg::S_LOAD: begin
					if (accept) begin
						if (store_we) begin
							job_count_q <= hrrn_pkg::COUNT_W'(job_count_q + 1'b1);
						end
						if (last_job) begin
							n_q          <= store_we ? hrrn_pkg::COUNT_W'(job_count_q + 1'b1)
								: job_count_q;
							dispatched_q <= '0;
							// start from tick zero; an idle round jumps to the first arrival
							now_q        <= '0;
							state_q      <= hrrn_pkg::S_PREP;
						end
					end
				end
				hrrn_pkg::S_PREP: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= hrrn_pkg::S_MUL;
				end
				hrrn_pkg::S_MUL: begin
					state_q <= hrrn_pkg::S_CMP;
				end
				hrrn_pkg::S_CMP: begin
					if (take_cand) begin
						found_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= hrrn_pkg::S_DECIDE;
					end else begin
						idx_q   <= hrrn_pkg::SLOT_W'(idx_q + 1'b1);
						state_q <= hrrn_pkg::S_MUL;
					end
				end
				hrrn_pkg::S_DECIDE: begin
					if (found_q) begin
						result_valid <= 1'b1;
						now_q        <= finish_now;
						dispatched_q <= hrrn_pkg::COUNT_W'(dispatched_q + 1'b1);
						if (batch_end) begin
							done_q      <= '0;
							job_count_q <= '0;
							state_q     <= hrrn_pkg::S_LOAD;
						end else begin
							done_q[best_slot_q] <= 1'b1;
							state_q             <= hrrn_pkg::S_PREP;
						end
					end else begin
						// nothing has arrived: jump to the earliest undone arrival
						now_q   <= hrrn_pkg::TIME_W'(min_q);
						state_q <= hrrn_pkg::S_PREP;
					end
				end
				default: begin
					state_q <= hrrn_pkg::S_LOAD;
				end
			endcase
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (state_q == hrrn_pkg::S_PREP) begin
			min_q <= '1;
		end
		if (state_q == hrrn_pkg::S_MUL) begin
			cand_id_q     <= rd_data.id;
			cand_arr_q    <= rd_data.arrival;
			cand_burst_q  <= rd_data.burst;
			cand_num_q    <= rd_num;
			cand_undone_q <= !done_q[idx_q];
			cand_ready_q  <= !done_q[idx_q]
				&& (hrrn_pkg::TIME_W'(rd_data.arrival) <= now_q);
		end
		if (state_q == hrrn_pkg::S_CMP) begin
			if (cand_undone_q && (cand_arr_q < min_q)) begin
				min_q <= cand_arr_q;
			end
			if (take_cand) begin
				best_slot_q  <= idx_q;
				best_id_q    <= cand_id_q;
				best_arr_q   <= cand_arr_q;
				best_burst_q <= cand_burst_q;
				best_num_q   <= cand_num_q;
			end
		end
	end

	// schedule entry, shown for the one cycle that result_valid is high
	always_ff @(posedge clk) begin
		if ((state_q == hrrn_pkg::S_DECIDE) && found_q) begin
			sched_id    <= best_id_q;
			start_time  <= now_q;
			finish_time <= finish_now;
			last_entry  <= batch_end;
		end
	end

	// a schedule entry only follows a decide cycle that found a job
	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == hrrn_pkg::S_DECIDE))
		else $error("result strobe without a dispatch decision");

	// the batch never holds more jobs than there are slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_count_q <= hrrn_pkg::COUNT_W'(hrrn_pkg::MAX_PROCESSES))
		else $error("job count beyond capacity");

	// the scan never looks past the stored jobs
	a_scan_in_batch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hrrn_pkg::S_CMP) |-> (hrrn_pkg::COUNT_W'(idx_q) < n_q))
		else $error("scan index beyond batch size");

	// never more entries than jobs in the batch
	a_dispatch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (dispatched_q < n_q))
		else $error("dispatch count reached batch size while busy");

	// the final entry hands the block back to loading
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_entry) |-> !busy)
		else $error("still busy after the final schedule entry");

endmodule

@@ tb/hrrn_schedule_checker.sv @@
`timescale 1ns / 1ps
// schedule checker for the hrrn batch scheduler: watches job and entry transfers,
// predicts each batch's dispatch order and compares every schedule entry
// depends on hrrn_pkg

module hrrn_schedule_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [hrrn_pkg::ID_W-1:0]    job_id,
	input  logic [hrrn_pkg::ARR_W-1:0]   arrival_time,
	input  logic [hrrn_pkg::BURST_W-1:0] burst_time,
	input  logic                         last_job,
	input  logic                         result_valid,
	input  logic [hrrn_pkg::ID_W-1:0]    sched_id,
	input  logic [hrrn_pkg::TIME_W-1:0]  start_time,
	input  logic [hrrn_pkg::TIME_W-1:0]  finish_time,
	input  logic                         last_entry,
	output int                           fail_count,
	output int                           entries_due,
	output int                           entries_checked,
	output int                           batches_closed
);

	import hrrn_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] t_start;
		logic [TIME_W-1:0] t_finish;
		logic              t_last;
	} sched_entry_t;

	job_entry_t   batch_jobs [MAX_PROCESSES];
	bit           dispatched [MAX_PROCESSES];
	int           batch_fill;
	sched_entry_t sched_due [$];
	sched_entry_t due_head;

	// true when job a goes before job b at tick now (exact cross-multiplied ratios)
	function automatic bit ratio_wins(job_entry_t a, int slot_a, job_entry_t b, int slot_b,
			logic [TIME_W-1:0] now);
		logic [NUM_W-1:0]  num_a;
		logic [NUM_W-1:0]  num_b;
		logic [PROD_W-1:0] lhs;
		logic [PROD_W-1:0] rhs;
		num_a = NUM_W'(now) - NUM_W'(a.arrival) + NUM_W'(a.burst);
		num_b = NUM_W'(now) - NUM_W'(b.arrival) + NUM_W'(b.burst);
		lhs = PROD_W'(num_a) * PROD_W'(b.burst);
		rhs = PROD_W'(num_b) * PROD_W'(a.burst);
		if (lhs != rhs)
			return lhs > rhs;
		if (a.arrival != b.arrival)
			return a.arrival < b.arrival;
		return slot_a < slot_b;
	endfunction

	// best ready job not yet dispatched, -1 when nothing has arrived
	function automatic int best_ready(logic [TIME_W-1:0] now);
		int pick;
		pick = -1;
		for (int i = 0; i < batch_fill; i++) begin
			if (dispatched[i] || TIME_W'(batch_jobs[i].arrival) > now)
				continue;
			if (pick < 0 || ratio_wins(batch_jobs[i], i, batch_jobs[pick], pick, now))
				pick = i;
		end
		return pick;
	endfunction

	task automatic plan_batch();
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] next_arrival;
		int                pick;
		sched_entry_t      ent;
		for (int i = 0; i < MAX_PROCESSES; i++)
			dispatched[i] = 1'b0;
		now = TIME_W'(16'hFFFF);
		for (int i = 0; i < batch_fill; i++)
			if (TIME_W'(batch_jobs[i].arrival) < now)
				now = TIME_W'(batch_jobs[i].arrival);
		for (int k = 0; k < batch_fill; k++) begin
			pick = best_ready(now);
			if (pick < 0) begin
				// idle clock: jump to the earliest arrival still waiting
				next_arrival = '1;
				for (int i = 0; i < batch_fill; i++)
					if (!dispatched[i] && TIME_W'(batch_jobs[i].arrival) < next_arrival)
						next_arrival = TIME_W'(batch_jobs[i].arrival);
				now = next_arrival;
				pick = best_ready(now);
			end
			dispatched[pick] = 1'b1;
			ent.id = batch_jobs[pick].id;
			ent.t_start = now;
			now = now + TIME_W'(batch_jobs[pick].burst);
			ent.t_finish = now;
			ent.t_last = (k == batch_fill - 1);
			sched_due.push_back(ent);
		end
		batch_fill = 0;
		batches_closed++;
	endtask

	task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			batch_fill = 0;
			sched_due.delete();
			fail_count = 0;
			entries_checked = 0;
			batches_closed = 0;
		end else begin
			// entries first: none can belong to a batch closed at this same edge
			if (result_valid) begin
				if (sched_due.size() == 0) begin
					$display("%0t: schedule entry id %0h arrived with nothing expected",
						$time, sched_id);
					fail_count++;
				end else begin
					due_head = sched_due.pop_front();
					report_field("sched_id", 32'(due_head.id), 32'(sched_id));
					report_field("start_time", 32'(due_head.t_start), 32'(start_time));
					report_field("finish_time", 32'(due_head.t_finish), 32'(finish_time));
					report_field("last_entry", 32'(due_head.t_last), 32'(last_entry));
					entries_checked++;
				end
			end
			if (start && !busy) begin
				if (batch_fill < MAX_PROCESSES) begin
					batch_jobs[batch_fill].id = job_id;
					batch_jobs[batch_fill].arrival = arrival_time;
					batch_jobs[batch_fill].burst = (burst_time == '0) ? BURST_W'(1) : burst_time;
					batch_fill++;
				end
				if (last_job)
					plan_batch();
			end
		end
		entries_due = sched_due.size();
	end

endmodule

@@ tb/hrrn_batch_scheduler_core_tb.sv @@
`timescale 1ns / 1ps
// testbench top for hrrn_batch_scheduler_core: job stimulus, timeout and verdict
// depends on hrrn_pkg, hrrn_batch_scheduler_core and hrrn_schedule_checker

module hrrn_batch_scheduler_core_tb;

	import hrrn_pkg::*;

	localparam int RANDOM_JOBS  = 360;
	localparam int QUIET_TAIL   = 50;       // last jobs go out back to back
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 1000000;

	// flavors of random batch content
	typedef enum int {
		MIX_CLUSTER,    // arrivals packed close, short bursts: ratio contests
		MIX_SPREAD,     // arrivals far apart: idle clock jumps
		MIX_WIDE,       // every field fully random
		MIX_TIES,       // few arrival and burst values: equal ratios
		MIX_EDGES       // field extremes mixed with random values
	} batch_mix_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [ID_W-1:0]     job_id;
	logic [ARR_W-1:0]    arrival_time;
	logic [BURST_W-1:0]  burst_time;
	logic                last_job;
	logic                result_valid;
	logic [ID_W-1:0]     sched_id;
	logic [TIME_W-1:0]   start_time;
	logic [TIME_W-1:0]   finish_time;
	logic                last_entry;

	int fail_count;
	int entries_due;
	int entries_checked;
	int batches_closed;

	int cycle_count = 0;
	int jobs_sent = 0;
	int gap_odds = 0;       // percent chance of an idle burst before a job
	bit quiet = 1'b0;       // no idling at all

	hrrn_batch_scheduler_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.job_id       (job_id),
		.arrival_time (arrival_time),
		.burst_time   (burst_time),
		.last_job     (last_job),
		.result_valid (result_valid),
		.sched_id     (sched_id),
		.start_time   (start_time),
		.finish_time  (finish_time),
		.last_entry   (last_entry)
	);

	hrrn_schedule_checker schedule_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.job_id          (job_id),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.last_job        (last_job),
		.result_valid    (result_valid),
		.sched_id        (sched_id),
		.start_time      (start_time),
		.finish_time     (finish_time),
		.last_entry      (last_entry),
		.fail_count      (fail_count),
		.entries_due     (entries_due),
		.entries_checked (entries_checked),
		.batches_closed  (batches_closed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop: far above the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// one job transfer; start stays high from one job to the next unless an
	// idle burst is drawn, so start gets a single assignment per edge
	task automatic send_job(input logic [15:0] id, input logic [15:0] arr,
			input logic [15:0] bst, input logic fin);
		int gap;
		if (!quiet && $urandom_range(99) < gap_odds) begin
			gap = $urandom_range(1, 17);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		job_id <= id;
		arrival_time <= arr;
		burst_time <= bst;
		last_job <= fin;
		// transfer happens at the first edge that sees busy low
		do @(posedge clk); while (busy);
		jobs_sent++;
	endtask

	// a batch of n jobs, the last one closing it; beyond 64 jobs the extras drop
	task automatic make_batch(input int n, input batch_mix_t mix);
		logic [15:0] base;
		logic [15:0] arr;
		logic [15:0] bst;
		base = 16'($urandom_range(0, 65500));
		for (int i = 0; i < n; i++) begin
			case (mix)
				MIX_CLUSTER: begin
					arr = base + 16'($urandom_range(0, 15));
					bst = 16'($urandom_range(0, 8));
				end
				MIX_SPREAD: begin
					arr = 16'($urandom);
					bst = 16'($urandom_range(1, 200));
				end
				MIX_TIES: begin
					arr = base + 16'(4 * $urandom_range(0, 3));
					bst = 16'd1 << $urandom_range(0, 3);
				end
				MIX_EDGES: begin
					case ($urandom_range(0, 2))
						0: arr = 16'h0000;
						1: arr = 16'hFFFF;
						default: arr = 16'($urandom);
					endcase
					case ($urandom_range(0, 3))
						0: bst = 16'h0000;
						1: bst = 16'h0001;
						2: bst = 16'hFFFF;
						default: bst = 16'($urandom);
					endcase
				end
				default: begin
					arr = 16'($urandom);
					bst = 16'($urandom);
				end
			endcase
			send_job(16'($urandom), arr, bst, i == n - 1);
		end
	endtask

	initial begin
		int directed_jobs;
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		job_id = '0;
		arrival_time = '0;
		burst_time = '0;
		last_job = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// equal ratios: at tick 0 slots 0 and 2 tie on ratio and arrival, the
		// lower slot wins; at tick 10 the other two tie at 2, earlier arrival wins
		send_job(16'h0001, 16'd0, 16'd10, 1'b0);
		send_job(16'h0002, 16'd5, 16'd5, 1'b0);
		send_job(16'h0003, 16'd0, 16'd10, 1'b1);
		// zero bursts run one tick; the clock idles and jumps three times
		send_job(16'h0010, 16'd100, 16'd0, 1'b0);
		send_job(16'h0011, 16'd1000, 16'd3, 1'b0);
		send_job(16'h0012, 16'd50, 16'd0, 1'b1);
		// field extremes, finish times well above the 16-bit arrival range
		send_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_job(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
		send_job(16'hAAAA, 16'h5555, 16'h0001, 1'b0);
		send_job(16'h5555, 16'hAAAA, 16'h8000, 1'b1);
		// a batch of one job
		send_job(16'h1234, 16'd0, 16'd0, 1'b1);
		// long wait lets a short job overtake a long one
		send_job(16'h0020, 16'd0, 16'd20, 1'b0);
		send_job(16'h0021, 16'd1, 16'd2, 1'b0);
		send_job(16'h0022, 16'd2, 16'd30, 1'b0);
		send_job(16'h0023, 16'd3, 16'd1, 1'b1);
		directed_jobs = jobs_sent;

		// one overflow batch: 64 stored, a dropped job, then a dropped closing job
		gap_odds = 10;
		make_batch(MAX_PROCESSES + 2, MIX_CLUSTER);

		// mostly small batches, an occasional medium one
		while (jobs_sent < directed_jobs + RANDOM_JOBS) begin
			case ($urandom_range(0, 2))
				0: gap_odds = 0;
				1: gap_odds = 15;
				default: gap_odds = 50;
			endcase
			quiet = (jobs_sent >= directed_jobs + RANDOM_JOBS - QUIET_TAIL);
			n = ($urandom_range(0, 8) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
			make_batch(n, batch_mix_t'($urandom_range(0, 4)));
		end
		start <= 1'b0;

		// let the checker see the last closing job, then wait out the entries
		do @(posedge clk); while (entries_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d jobs in %0d batches; %0d schedule entries checked",
			jobs_sent, batches_closed, entries_checked);
		$display("ties, idle jumps, zero bursts, field extremes and a batch overflow included");
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ hrrn_batch_scheduler_core.f @@
sv/hrrn_pkg.sv
sv/hrrn_job_store.sv
sv/hrrn_ratio_unit.sv
sv/hrrn_batch_scheduler_core.sv
tb/hrrn_schedule_checker.sv
tb/hrrn_batch_scheduler_core_tb.sv
